// ===== sv/timestamped_key_value_floor_lookup_defines.svh =====
// assertion macros for the lookup rtl
`ifndef TIMESTAMPED_KEY_VALUE_FLOOR_LOOKUP_DEFINES_SVH
`define TIMESTAMPED_KEY_VALUE_FLOOR_LOOKUP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TKV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tkv_pkg.sv =====
// ----------------------------------------------------------------------------
// tkv_pkg
// shared constants and types of the timestamped key-value floor lookup
// ----------------------------------------------------------------------------
`default_nettype none

package tkv_pkg;

    localparam int KEY_SLOTS     = 16;
    localparam int HISTORY_DEPTH = 64;

    localparam int KEY_W   = 4;
    localparam int WORD_W  = 32;
    localparam int STAMP_W = 31;

    localparam int KEY_IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int ENTRIES   = KEY_SLOTS * HISTORY_DEPTH;
    localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ENTRY_W   = STAMP_W + WORD_W;
    localparam int KEY_CMP_W = KEY_W + 12;

    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SET,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/tkv_ram.sv =====
// ----------------------------------------------------------------------------
// tkv_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/timestamped_key_value_floor_lookup.sv =====
// ----------------------------------------------------------------------------
// timestamped_key_value_floor_lookup
// versioned key-value store: set appends (stamp, value) to a key's history,
// get returns the value with the greatest stamp at or below the query
// ----------------------------------------------------------------------------
// One item at a time. A set goes through S_SET and a get through S_SCAN, both
// then through S_DONE. S_SCAN feeds the key's fill_count entries through the
// single read port of the history ram, one stored entry per cycle, to the
// shared stamp comparator. A finished result waits in the output register
// while the next item is accepted; a full history drops the set with status 1.
`default_nettype none

module timestamped_key_value_floor_lookup
    import tkv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_command,
    input  wire logic [KEY_W-1:0]   i_key_id,
    input  wire logic [WORD_W-1:0]  i_stored_value,
    input  wire logic [STAMP_W-1:0] i_stamp,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_status,
    output logic                    o_found,
    output logic [WORD_W-1:0]       o_result_value
);

`include "timestamped_key_value_floor_lookup_defines.svh"

    t_state r_state;
    t_state n_state;

    logic                 r_cmd;
    logic                 r_key_ok;
    logic [KEY_IDX_W-1:0] r_key;
    logic [WORD_W-1:0]    r_word;
    logic [STAMP_W-1:0]   r_query;
    logic [FILL_W-1:0]    r_n;
    logic [FILL_W-1:0]    r_idx;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_pend;
    logic [STAMP_W-1:0]   r_best;
    logic                 r_found;
    logic [WORD_W-1:0]    r_value;
    logic [FILL_W-1:0]    r_fill [KEY_SLOTS];

    logic                 r_out_valid;
    logic                 r_out_status;
    logic                 r_out_found;
    logic [WORD_W-1:0]    r_out_value;

    logic                 accept;
    logic                 key_ok;
    logic [KEY_IDX_W-1:0] key_idx;
    logic                 set_full;
    logic                 ram_we;
    logic                 ram_re;
    logic                 out_load;
    logic                 scan_end;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [STAMP_W-1:0]   rd_stamp;
    logic [WORD_W-1:0]    rd_word;
    logic                 hit;

    assign key_ok   = KEY_CMP_W'(i_key_id) < KEY_CMP_W'(KEY_SLOTS);
    assign key_idx  = KEY_IDX_W'(i_key_id);
    assign set_full = !r_key_ok || (r_n >= FILL_W'(HISTORY_DEPTH));
    assign scan_end = (r_idx == r_n);
    assign accept   = i_valid && !o_stall;

    assign rd_stamp = ram_rdata[ENTRY_W-1:WORD_W];
    assign rd_word  = ram_rdata[WORD_W-1:0];
    assign hit      = r_pend && (rd_stamp != '0) && (rd_stamp <= r_query)
                      && (rd_stamp >= r_best);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_command == CMD_GET) ? S_SCAN : S_SET;
                end
            end
            S_SET: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_stall  = 1'b1;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_SET: begin
                ram_we = !set_full;
            end
            S_SCAN: begin
                ram_re = !scan_end;
            end
            S_DONE: begin
                out_load = !r_out_valid || !i_stall;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            for (int k = 0; k < KEY_SLOTS; k++) begin
                r_fill[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= ram_re;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_fill[r_key] <= r_n + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_command;
            r_key_ok <= key_ok;
            r_key    <= key_idx;
            r_word   <= i_stored_value;
            r_query  <= i_stamp;
            r_n      <= key_ok ? r_fill[key_idx] : '0;
            r_idx    <= '0;
            r_addr   <= ADDR_W'(ADDR_W'(key_idx) * HISTORY_DEPTH);
            r_best   <= '0;
            r_found  <= 1'b0;
            r_value  <= '0;
        end else begin
            if (ram_re) begin
                r_idx  <= r_idx + 1'b1;
                r_addr <= r_addr + 1'b1;
            end
            if (hit) begin
                r_best  <= rd_stamp;
                r_found <= 1'b1;
                r_value <= rd_word;
            end
        end
        if (out_load) begin
            r_out_status <= (r_cmd == CMD_SET) && set_full;
            r_out_found  <= (r_cmd == CMD_GET) && r_found;
            r_out_value  <= (r_cmd == CMD_GET) ? r_value : '0;
        end
    end

    tkv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr + ADDR_W'(r_n)),
        .i_wdata ({r_query, r_word}),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found        = r_out_found;
    assign o_result_value = r_out_value;

    `TKV_ASSERT_NOW(a_scan_bound, r_state == S_SCAN, r_idx <= r_n, "scan ran past fill count")
    `TKV_ASSERT_NOW(a_write_room, ram_we, r_cmd == CMD_SET && r_n < FILL_W'(HISTORY_DEPTH),
        "history write without room")
    `TKV_ASSERT_NOW(a_drop_empty, o_valid && o_status, !o_found && o_result_value == '0,
        "dropped set carries a value")
    `TKV_ASSERT_NEXT(a_busy_after_accept, accept, r_state != S_IDLE && o_stall,
        "block idle right after accepting an item")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the timestamped key-value floor lookup against a behavioral model:
// a short table of directed items, then random sets and gets aimed at a few
// busy keys so that histories fill up, with random idling on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import tkv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_DROPPED = 1'b1;
    localparam logic TYPED      = 1'b1;
    localparam logic PREDICTED  = 1'b0;

    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = HISTORY_DEPTH + 16;
    localparam int LONG_HOLD    = 200;
    localparam int PROBE_COUNT  = 22;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    typedef struct packed {
        logic              status;
        logic              found;
        logic [WORD_W-1:0] value;
    } t_result;

    typedef struct packed {
        logic               cmd;
        logic [KEY_W-1:0]   key;
        logic [WORD_W-1:0]  word;
        logic [STAMP_W-1:0] stamp;
        logic               typed;
        t_result            res;
    } t_probe_row;

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               i_command      = CMD_SET;
    logic [KEY_W-1:0]   i_key_id       = '0;
    logic [WORD_W-1:0]  i_stored_value = '0;
    logic [STAMP_W-1:0] i_stamp        = '0;
    logic               i_stall        = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic               o_status;
    logic               o_found;
    logic [WORD_W-1:0]  o_result_value;

    // model of the key histories
    logic [STAMP_W-1:0] hist_stamp [KEY_SLOTS][HISTORY_DEPTH];
    logic [WORD_W-1:0]  hist_word  [KEY_SLOTS][HISTORY_DEPTH];
    int                 hist_fill  [KEY_SLOTS];

    t_result pending_results [$];

    int items_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int set_count     = 0;
    int dropped_count = 0;
    int get_count     = 0;
    int hit_count     = 0;
    int cycles        = 0;

    // directed items: empty key, exact and floor hits, equal stamps,
    // extremes of value and stamp, stamp zero, value ignored on get
    t_probe_row probe_rows [PROBE_COUNT] = '{
        '{CMD_GET, 4'd0,  32'h0000_0000, STAMP_MAX,     TYPED, '{ST_OK, 1'b0, 32'h0}},
        '{CMD_SET, 4'd0,  32'hDEAD_BEEF, 31'd10,        TYPED, '{ST_OK, 1'b0, 32'h0}},
        '{CMD_GET, 4'd0,  32'h0000_0000, 31'd9,         TYPED, '{ST_OK, 1'b0, 32'h0}},
        '{CMD_GET, 4'd0,  32'h0000_0000, 31'd10,        TYPED,
          '{ST_OK, 1'b1, 32'hDEAD_BEEF}},
        '{CMD_GET, 4'd0,  32'h0000_0000, STAMP_MAX,     TYPED,
          '{ST_OK, 1'b1, 32'hDEAD_BEEF}},
        '{CMD_SET, 4'd0,  32'h1234_5678, 31'd10,        TYPED, '{ST_OK, 1'b0, 32'h0}},
        '{CMD_GET, 4'd0,  32'h0000_0000, 31'd10,        TYPED,
          '{ST_OK, 1'b1, 32'h1234_5678}},
        '{CMD_SET, 4'd0,  32'h0000_0000, 31'd5,         TYPED, '{ST_OK, 1'b0, 32'h0}},
        '{CMD_GET, 4'd0,  32'h0000_0000, 31'd7,         TYPED, '{ST_OK, 1'b1, 32'h0}},
        '{CMD_SET, 4'd15, 32'hFFFF_FFFF, STAMP_MAX,     TYPED, '{ST_OK, 1'b0, 32'h0}},
        '{CMD_GET, 4'd15, 32'h0000_0000, STAMP_MAX - 31'd1, TYPED,
          '{ST_OK, 1'b0, 32'h0}},
        '{CMD_GET, 4'd15, 32'h0000_0000, STAMP_MAX,     TYPED,
          '{ST_OK, 1'b1, 32'hFFFF_FFFF}},
        '{CMD_SET, 4'd15, 32'h0000_0055, 31'd1,         TYPED, '{ST_OK, 1'b0, 32'h0}},
        '{CMD_GET, 4'd15, 32'h0000_0000, 31'd1,         TYPED,
          '{ST_OK, 1'b1, 32'h0000_0055}},
        '{CMD_SET, 4'd3,  32'hAAAA_5555, 31'd0,         TYPED, '{ST_OK, 1'b0, 32'h0}},
        '{CMD_GET, 4'd3,  32'h0000_0000, STAMP_MAX,     TYPED, '{ST_OK, 1'b0, 32'h0}},
        '{CMD_GET, 4'd0,  32'h0000_0000, 31'd0,         TYPED, '{ST_OK, 1'b0, 32'h0}},
        '{CMD_SET, 4'd7,  32'h0F0F_0F0F, 31'd100,       PREDICTED, '0},
        '{CMD_SET, 4'd7,  32'hF0F0_F0F0, 31'd50,        PREDICTED, '0},
        '{CMD_GET, 4'd7,  32'h0000_0000, 31'd75,        PREDICTED, '0},
        '{CMD_GET, 4'd7,  32'h0000_0000, 31'd200,       PREDICTED, '0},
        '{CMD_GET, 4'd0,  32'hFFFF_FFFF, 31'd10,        PREDICTED, '0}
    };

    timestamped_key_value_floor_lookup dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_key_id       (i_key_id),
        .i_stored_value (i_stored_value),
        .i_stamp        (i_stamp),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_result_value (o_result_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // append on set, floor search in write order on get
    function automatic t_result floor_store_step(logic cmd, logic [KEY_W-1:0] key,
                                                 logic [WORD_W-1:0] word,
                                                 logic [STAMP_W-1:0] stamp);
        t_result            r;
        logic [STAMP_W-1:0] best;
        int                 n;
        r    = '0;
        best = '0;
        n    = hist_fill[key];
        if (cmd == CMD_SET) begin
            set_count++;
            if (n >= HISTORY_DEPTH) begin
                r.status = ST_DROPPED;
                dropped_count++;
            end else begin
                hist_stamp[key][n] = stamp;
                hist_word[key][n]  = word;
                hist_fill[key]     = n + 1;
            end
        end else begin
            get_count++;
            for (int i = 0; i < n; i++) begin
                if (hist_stamp[key][i] != '0 && hist_stamp[key][i] <= stamp &&
                        hist_stamp[key][i] >= best) begin
                    best    = hist_stamp[key][i];
                    r.found = 1'b1;
                    r.value = hist_word[key][i];
                end
            end
            if (r.found)
                hit_count++;
        end
        return r;
    endfunction

    task automatic offer_item(logic cmd, logic [KEY_W-1:0] key, logic [WORD_W-1:0] word,
                              logic [STAMP_W-1:0] stamp, logic typed, t_result typed_res);
        int      gap;
        t_result r;
        gap = ((items_sent % 200) >= 170) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_key_id       <= key;
        i_stored_value <= word;
        i_stamp        <= stamp;
        do @(posedge i_clk); while (o_stall);
        r = floor_store_step(cmd, key, word, stamp);
        pending_results = {pending_results, (typed ? typed_res : r)};
        items_sent++;
    endtask

    // result side: random stall per item, one long hold-off
    initial begin
        int      hold;
        t_result want;
        wait (i_rst_n);
        forever begin
            if (results_seen == 300)
                hold = LONG_HOLD;
            else if ((results_seen % 250) >= 210)
                hold = 0;
            else
                hold = $urandom_range(0, 6);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0b found %0b value %h",
                         $time, o_status, o_found, o_result_value);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0b, got %0b",
                             $time, want.status, o_status);
                    mismatches++;
                end
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch: expected %0b, got %0b",
                             $time, want.found, o_found);
                    mismatches++;
                end
                if (o_result_value !== want.value) begin
                    $display("%0t: result_value mismatch: expected %h, got %h",
                             $time, want.value, o_result_value);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t: timeout with %0d results outstanding",
                         $time, pending_results.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic               cmd;
        logic [KEY_W-1:0]   key;
        logic [WORD_W-1:0]  word;
        logic [STAMP_W-1:0] stamp;
        int                 pick;
        int                 nudge;

        for (int k = 0; k < KEY_SLOTS; k++)
            hist_fill[k] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < PROBE_COUNT; p++)
            offer_item(probe_rows[p].cmd, probe_rows[p].key, probe_rows[p].word,
                       probe_rows[p].stamp, probe_rows[p].typed, probe_rows[p].res);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // sender holds back until the block has drained
            if (n == 650) begin
                i_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge i_clk);
            end
            cmd  = ($urandom_range(0, 9) < 6) ? CMD_SET : CMD_GET;
            key  = ($urandom_range(0, 9) < 4) ? KEY_W'($urandom_range(0, 2))
                                              : KEY_W'($urandom_range(0, 15));
            word = $urandom;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                stamp = STAMP_W'($urandom_range(1, 64));
            else if (pick < 8)
                stamp = STAMP_W'($urandom);
            else if (pick == 8)
                stamp = STAMP_MAX;
            else
                stamp = 31'd1;
            // gets often probe around a stamp already in the history
            if (cmd == CMD_GET && hist_fill[key] > 0 && $urandom_range(0, 1) == 1) begin
                stamp = hist_stamp[key][$urandom_range(0, hist_fill[key] - 1)];
                nudge = $urandom_range(0, 2);
                if (nudge == 0 && stamp > 31'd1)
                    stamp = stamp - 31'd1;
                else if (nudge == 2 && stamp != STAMP_MAX)
                    stamp = stamp + 31'd1;
            end
            if (stamp == '0)
                stamp = 31'd1;
            offer_item(cmd, key, word, stamp, PREDICTED, '0);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items: %0d sets (%0d dropped on a full history),",
                 items_sent, set_count, dropped_count);
        $display("%0d gets (%0d hits), %0d results checked, %0d mismatches",
                 get_count, hit_count, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
